[sv/psba_pkg.sv]
`default_nettype none

package psba_pkg;

  // Bitmap word width; one word is examined per scan cycle
  localparam int WORD_BITS = 64;
  localparam int POS_W     = 6;
  localparam int ADDR_W    = 32;

  // Request kinds carried on s_tuser
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Configuration register indexes
  localparam logic REG_REGION_BASE = 1'b0;
  localparam logic REG_REGION_END  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC_WR,
    ST_REL_CHK,
    ST_REL_WR,
    ST_PUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic rd_first;      // start scan at word 0
    logic scan_next;     // advance scan to the next word
    logic hit_save;      // capture the updated word and slot of the hit
    logic alloc_commit;  // write back the word, stage grant result
    logic fail_result;   // stage a failed result
    logic rel_latch;     // capture the release address
    logic rel_check;     // check window and alignment, stage result
    logic rel_commit;    // clear the slot bit
    logic push;          // move staged result to the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;             // current word has a free slot
    logic last_word;       // current word is the last one
    logic rel_need_write;  // release is valid and inside the slot range
    logic out_free;        // output register can take a result
  } status_t;

endpackage

`default_nettype wire

[sv/psba_ctrl.sv]
`default_nettype none

module psba_ctrl import psba_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_kind,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_ALLOC) begin
            cmd.rd_first = 1'b1;
            state_next   = ST_SCAN;
          end else begin
            cmd.rel_latch = 1'b1;
            state_next    = ST_REL_CHK;
          end
        end
      end
      ST_SCAN: begin
        if (status.hit) begin
          cmd.hit_save = 1'b1;
          state_next   = ST_ALLOC_WR;
        end else if (status.last_word) begin
          cmd.fail_result = 1'b1;
          state_next      = ST_PUSH;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_ALLOC_WR: begin
        cmd.alloc_commit = 1'b1;
        state_next       = ST_PUSH;
      end
      ST_REL_CHK: begin
        cmd.rel_check = 1'b1;
        state_next    = status.rel_need_write ? ST_REL_WR : ST_PUSH;
      end
      ST_REL_WR: begin
        cmd.rel_commit = 1'b1;
        state_next     = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/psba_dpath.sv]
`default_nettype none

module psba_dpath import psba_pkg::*; #(
  parameter int SLOT_COUNT = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_success,
  output logic [ADDR_W-1:0]      out_address
);

  localparam int WORDS     = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int HSLOT_W   = WIDX_W + POS_W;
  localparam int LAST_BITS = SLOT_COUNT - WORD_BITS * (WORDS - 1);
  localparam logic [WORD_BITS-1:0] LAST_MASK = (LAST_BITS == WORD_BITS) ? '1 :
      ((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
  localparam logic [ADDR_W-1:0] PAGE_MASK =
      ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(WORDS - 1);

  // Configuration registers
  logic [ADDR_W-1:0] region_base, region_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_end  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_REGION_BASE) region_base <= cfg_data;
      if (cfg_index == REG_REGION_END)  region_end  <= cfg_data;
    end
  end

  // Bitmap memory with per-word valid bits; an invalid word reads as all free
  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     word_valid;
  logic [WORD_BITS-1:0] mem_q;
  logic                 rd_vld;
  logic                 rd_en;
  logic [WIDX_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [WIDX_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      rd_vld <= word_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (wr_en) begin
      word_valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_word = rd_vld ? mem_q : '0;

  // Scan word index
  logic [WIDX_W-1:0] widx;

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      widx <= '0;
    end else if (cmd.scan_next) begin
      widx <= WIDX_W'(widx + 1'b1);
    end
  end

  // Free-slot search in the current word, lowest bit first
  logic [WORD_BITS-1:0] free_bits;
  logic [POS_W-1:0]     free_pos;

  always_comb begin
    free_bits = ~rd_word & ((widx == LAST_WIDX) ? LAST_MASK : '1);
    free_pos  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) free_pos = POS_W'(i);
    end
  end

  // Hit capture
  logic [WORD_BITS-1:0] hit_word;
  logic [HSLOT_W-1:0]   hit_slot;

  always_ff @(posedge clk) begin
    if (cmd.hit_save) begin
      hit_word <= rd_word | (WORD_BITS'(1) << free_pos);
      hit_slot <= {widx, free_pos};
    end
  end

  // Release checks
  logic [ADDR_W-1:0] rel_addr;
  logic [ADDR_W-1:0] rel_offset;
  logic [ADDR_W-1:0] rel_slot;
  logic              rel_ok;
  logic              rel_in_range;
  logic [WIDX_W-1:0] rel_widx;
  logic [POS_W-1:0]  rel_bit;

  always_ff @(posedge clk) begin
    if (cmd.rel_latch) rel_addr <= in_address;
    if (cmd.rel_check) begin
      rel_widx <= rel_slot[POS_W +: WIDX_W];
      rel_bit  <= rel_slot[POS_W-1:0];
    end
  end

  always_comb begin
    rel_offset   = rel_addr - region_base;
    rel_slot     = rel_offset >> PAGE_SHIFT;
    rel_ok       = (rel_addr != '0) && (rel_addr >= region_base) &&
                   (rel_addr < region_end) && ((rel_offset & PAGE_MASK) == '0);
    rel_in_range = rel_slot < ADDR_W'(SLOT_COUNT);
  end

  // Memory port steering
  always_comb begin
    rd_en   = cmd.rd_first | cmd.scan_next | cmd.rel_check;
    rd_addr = '0;
    if (cmd.scan_next) begin
      rd_addr = WIDX_W'(widx + 1'b1);
    end else if (cmd.rel_check) begin
      rd_addr = rel_slot[POS_W +: WIDX_W];
    end
    wr_en   = cmd.alloc_commit | (cmd.rel_commit);
    wr_addr = cmd.alloc_commit ? widx : rel_widx;
    wr_data = cmd.alloc_commit ? hit_word : (rd_word & ~(WORD_BITS'(1) << rel_bit));
  end

  // Staged result and output register
  logic              res_success;
  logic [ADDR_W-1:0] res_address;

  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      res_success <= 1'b1;
      res_address <= region_base + (ADDR_W'(hit_slot) << PAGE_SHIFT);
    end else if (cmd.fail_result) begin
      res_success <= 1'b0;
      res_address <= '0;
    end else if (cmd.rel_check) begin
      res_success <= rel_ok;
      res_address <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_success <= res_success;
      out_address <= res_address;
    end
  end

  // Status back to the controller
  always_comb begin
    status.hit            = |free_bits;
    status.last_word      = (widx == LAST_WIDX);
    status.rel_need_write = rel_ok & rel_in_range;
    status.out_free       = ~out_valid | out_ready;
  end

endmodule

`default_nettype wire

[sv/page_slot_bitmap_allocator_top.sv]
// First-fit page-slot allocator over a bitmap of SLOT_COUNT slots of
// 2^PAGE_SHIFT bytes starting at region_base.
// Input stream (s_*): one request per transfer; s_tuser is the kind
// (0 allocate, 1 release), s_tdata the address to release.
// Output stream (m_*): one result per request; m_tuser is success,
// m_tdata the granted address (0 on failure and for every release).
// Configuration: cfg_we writes cfg_data to region_base (index 0) or
// region_end (index 1); write only while no request is in flight.
// One request is worked at a time. Allocate reads the bitmap memory one
// 64-bit word per cycle, from word 0 up to the first word with a free
// slot or, on failure, the last of the ceil(SLOT_COUNT/64) words. Release
// checks the address and clears its slot bit only if it is valid and in
// range. s_tready rises again once the result is in the output register.
// The output register holds a result while m_tready is low; the block
// still takes one new request and works it, then waits before moving
// that result out until the held one has left.
// Synchronous reset empties the bitmap at once (per-word valid bits), clears
// both registers and drops m_tvalid; no clearing pass is needed.
`default_nettype none

module page_slot_bitmap_allocator_top import psba_pkg::*; #(
  parameter int SLOT_COUNT = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [ADDR_W-1:0] s_tdata,   // [31:0] release_address
  input  wire logic              s_tuser,   // [0] kind
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [ADDR_W-1:0]      m_tdata,   // [31:0] granted_address
  output logic                   m_tuser,   // [0] success
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  psba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  psba_dpath #(
    .SLOT_COUNT (SLOT_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_address  (s_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_success (m_tuser),
    .out_address (m_tdata)
  );

  // A failed result never carries an address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("failed result with nonzero address");

  // Only one request is in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  // A result is moved to the output only when the register can take it
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> status.out_free)
    else $error("result pushed into a full output register");

  // Allocate and release never write the bitmap in the same cycle
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.alloc_commit && cmd.rel_commit))
    else $error("conflicting bitmap writes");

endmodule

`default_nettype wire

[tb/sv/slot_grant_monitor.sv]
`timescale 1ns / 100ps

// Watches the request, result and register-write channels of the allocator,
// keeps its own slot map and window registers, and compares every result
// transfer against the oldest predicted grant.
module slot_grant_monitor import psba_pkg::*; #(
  parameter int SLOT_COUNT = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [ADDR_W-1:0] s_tdata,
  input  wire logic              s_tuser,
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [ADDR_W-1:0] m_tdata,
  input  wire logic              m_tuser,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data,
  output int                     outstanding,
  output int                     error_count
);

  typedef struct packed {
    logic              success;
    logic [ADDR_W-1:0] addr;
  } grant_t;

  localparam logic [ADDR_W-1:0] PAGE_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;

  // Shadow state of the block
  bit                slot_used [SLOT_COUNT];
  logic [ADDR_W-1:0] window_base;
  logic [ADDR_W-1:0] window_limit;
  grant_t            expected_grants [$];
  int                failures;

  // Apply one request to the shadow map and return the result it must give
  function automatic grant_t predict_request(logic kind, logic [ADDR_W-1:0] addr);
    grant_t            r;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] slot_idx;
    bit                found;
    r.success = 1'b0;
    r.addr    = '0;
    found     = 1'b0;
    if (kind == KIND_ALLOC) begin
      // first fit; the address wraps modulo 2^32
      for (int slot = 0; slot < SLOT_COUNT; slot++) begin
        if (!found && !slot_used[slot]) begin
          slot_used[slot] = 1'b1;
          r.success       = 1'b1;
          r.addr          = window_base + (32'(slot) << PAGE_SHIFT);
          found           = 1'b1;
        end
      end
    end else if (addr != '0 && addr >= window_base && addr < window_limit) begin
      offset = addr - window_base;
      if ((offset & PAGE_MASK) == '0) begin
        slot_idx = offset >> PAGE_SHIFT;
        // aligned but past the last slot: nothing changes, still a success
        if (slot_idx < 32'(SLOT_COUNT))
          slot_used[slot_idx] = 1'b0;
        r.success = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    grant_t exp_grant;
    if (rst) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      window_base  = '0;
      window_limit = '0;
      expected_grants.delete();
      failures     = 0;
      outstanding <= 0;
      error_count <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == REG_REGION_BASE)
          window_base = cfg_data;
        else
          window_limit = cfg_data;
      end

      // request transfer
      if (s_tvalid && s_tready)
        expected_grants.push_back(predict_request(s_tuser, s_tdata));

      // result transfer
      if (m_tvalid && m_tready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result: success %0b addr %h", $time, m_tuser, m_tdata);
          failures++;
        end else begin
          exp_grant = expected_grants.pop_front();
          if (m_tuser !== exp_grant.success) begin
            $display("%0t: success mismatch: expected %0b, actual %0b",
                     $time, exp_grant.success, m_tuser);
            failures++;
          end
          if (m_tdata !== exp_grant.addr) begin
            $display("%0t: granted address mismatch: expected %h, actual %h",
                     $time, exp_grant.addr, m_tdata);
            failures++;
          end
        end
      end

      outstanding <= expected_grants.size();
      error_count <= failures;
    end
  end

endmodule

[tb/sv/page_slot_bitmap_allocator_top_tb.sv]
`timescale 1ns / 100ps

module page_slot_bitmap_allocator_top_tb;
  import psba_pkg::*;

  localparam int SLOT_COUNT = 256;
  localparam int PAGE_SHIFT = 12;
  localparam logic [ADDR_W-1:0] PAGE_BYTES = 32'd1 << PAGE_SHIFT;
  localparam int STALL_LIMIT = 2000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [ADDR_W-1:0] s_tdata   = '0;
  logic              s_tuser   = KIND_ALLOC;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [ADDR_W-1:0] m_tdata;
  logic              m_tuser;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = REG_REGION_BASE;
  logic [ADDR_W-1:0] cfg_data  = '0;

  int outstanding;
  int error_count;

  // Stimulus-side view of the window and the traffic mix
  logic [ADDR_W-1:0] cur_base  = '0;
  logic [ADDR_W-1:0] cur_limit = '0;
  int                alloc_pct = 50;
  bit                idle_on   = 1'b1;
  int                ready_wait = 0;
  int unsigned       stall_draw;
  int                quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  page_slot_bitmap_allocator_top #(
    .SLOT_COUNT(SLOT_COUNT),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  slot_grant_monitor #(
    .SLOT_COUNT(SLOT_COUNT),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) grant_mon (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outstanding(outstanding), .error_count(error_count)
  );

  // Result side: random stall after each transfer
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      stall_draw = idle_on ? $urandom_range(0, 5) : 0;
      ready_wait <= stall_draw;
      m_tready   <= (stall_draw == 0);
    end else if (ready_wait > 0) begin
      ready_wait <= ready_wait - 1;
      m_tready   <= (ready_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request transfer, after a random gap with tvalid low
  task automatic send_request(logic kind, logic [ADDR_W-1:0] addr);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drain all results, let the block settle, then write both registers
  task automatic set_window(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] limit);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REGION_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= REG_REGION_END;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_base  = base;
    cur_limit = limit;
  endtask

  // Release address: mostly slot-aligned inside the window, the rest noise
  function automatic logic [ADDR_W-1:0] make_release_address();
    int                pick;
    logic [ADDR_W-1:0] slot;
    pick = $urandom_range(0, 99);
    slot = 32'($urandom_range(0, SLOT_COUNT - 1));
    if (pick < 60)
      return cur_base + (slot << PAGE_SHIFT);
    else if (pick < 70)
      return cur_base + (32'($urandom_range(SLOT_COUNT, SLOT_COUNT + 15)) << PAGE_SHIFT);
    else if (pick < 80)
      return cur_base + (slot << PAGE_SHIFT) + 32'($urandom_range(1, PAGE_BYTES - 1));
    else if (pick < 90)
      return $urandom;
    else if (pick < 95) begin
      case ($urandom_range(0, 3))
        0:       return cur_base - 32'd1;
        1:       return cur_limit;
        2:       return cur_limit - PAGE_BYTES;
        default: return cur_base;
      endcase
    end
    return '0;
  endfunction

  // Random traffic; mix and idling are redrawn every 40 requests
  task automatic run_random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0:       alloc_pct = 20;
          1:       alloc_pct = 50;
          default: alloc_pct = 85;
        endcase
      end
      if ($urandom_range(0, 99) < alloc_pct)
        send_request(KIND_ALLOC, $urandom);
      else
        send_request(KIND_RELEASE, make_release_address());
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] rnd_base;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Registers at reset value: slot 0 grants address 0, empty window
    send_request(KIND_ALLOC, 32'hFFFF_FFFF);
    send_request(KIND_RELEASE, 32'h0000_0000);
    send_request(KIND_RELEASE, PAGE_BYTES);

    // Window with a few aligned pages past the last slot
    set_window(32'h4000_0000, 32'h4000_0000 + (32'(SLOT_COUNT + 8) << PAGE_SHIFT));
    send_request(KIND_ALLOC, 32'h0);
    send_request(KIND_ALLOC, 32'h0);
    send_request(KIND_RELEASE, cur_base + PAGE_BYTES);
    send_request(KIND_RELEASE, cur_base + PAGE_BYTES);     // already free
    send_request(KIND_ALLOC, 32'h0);
    send_request(KIND_RELEASE, cur_base + (PAGE_BYTES >> 1)); // misaligned
    send_request(KIND_RELEASE, cur_base - PAGE_BYTES);     // below window
    send_request(KIND_RELEASE, cur_limit);                 // at window end
    send_request(KIND_RELEASE, cur_limit - PAGE_BYTES);    // past slot range
    send_request(KIND_RELEASE, 32'hFFFF_FFFF);
    send_request(KIND_RELEASE, cur_base);
    send_request(KIND_ALLOC, 32'h0);

    // Fill every slot near the top of the address space: grants wrap,
    // then allocation runs out
    set_window(32'hFFF8_0000, 32'hFFFF_FFFF);
    repeat (SLOT_COUNT + 4) send_request(KIND_ALLOC, $urandom);
    send_request(KIND_RELEASE, cur_base + (32'd5 << PAGE_SHIFT));
    send_request(KIND_ALLOC, 32'h0);
    send_request(KIND_RELEASE, 32'hFFFF_F000);
    send_request(KIND_RELEASE, 32'h0000_0000);
    send_request(KIND_ALLOC, 32'h0);

    // Random phases across window settings, extremes included
    set_window(32'h1000_0000, 32'h1000_0000 + (32'(SLOT_COUNT + 8) << PAGE_SHIFT));
    run_random_phase(220);
    set_window(32'h0000_0000, 32'hFFFF_FFFF);
    run_random_phase(220);
    set_window(32'h1234_5678, 32'h1234_5678 + (32'd300 << PAGE_SHIFT));
    run_random_phase(220);
    set_window(32'h8000_0000, 32'h1000_0000);              // inverted window
    run_random_phase(220);
    set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random_phase(220);
    set_window($urandom, $urandom);
    run_random_phase(220);
    rnd_base = $urandom;
    set_window(rnd_base, rnd_base + (32'($urandom_range(1, SLOT_COUNT + 32)) << PAGE_SHIFT));
    run_random_phase(220);

    // Wait for the last results, then give the verdict
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (12) @(posedge clk);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
